>>> design/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared widths, codes and types of the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 35;
  localparam int DIM_REG_W = 4;
  localparam int POS_W     = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

>>> design/dmm_mac.sv
// ----------------------------------------------------------------------------
// dmm_mac
// Multiply-accumulate pipeline: registered product, then exact running sum.
// ----------------------------------------------------------------------------
module dmm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [dmm_pkg::ELEM_W-1:0] a_data,
  input  logic signed [dmm_pkg::ELEM_W-1:0] b_data,
  input  dmm_pkg::mac_ctrl_t                ctrl,
  input  logic                              take,
  output logic signed [dmm_pkg::SUM_W-1:0]  acc,
  output logic                              done
);
  import dmm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  mac_ctrl_t                s2_ctrl_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_nxt;
  logic                     done_r;
  logic                     done_nxt;

  assign prod_nxt = a_data * b_data;
  assign acc_nxt  = (s2_ctrl_r.first ? '0 : acc_r) + SUM_W'(prod_r);

  always_comb begin
    done_nxt = done_r;
    if (take) begin
      done_nxt = 1'b0;
    end
    if (s2_ctrl_r.valid && s2_ctrl_r.last) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r <= '0;
      done_r    <= 1'b0;
    end else begin
      s2_ctrl_r <= ctrl;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (s2_ctrl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> design/dense_matrix_multiply.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// Fixed-point C = A x B over two element memories and one shared MAC.
// ----------------------------------------------------------------------------
// A write word stores one Q8.8 element of A or B and the block takes the
// next word right after. A compute word stalls the input until the whole
// product is out: each of the a_rows x b_cols elements takes inner_size
// memory read pairs and multiply-accumulates, one per cycle, and then waits
// while the output is stalled. Results leave in row-major order with out_last
// on the final element. Elements never written read as unknown. Dimension
// registers read as 0 count as 1 and saturate at MAX_DIM.
module dense_matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dmm_pkg::DIM_REG_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dmm_pkg::CMD_W-1:0]            in_command,
  input  logic [dmm_pkg::POS_W-1:0]            in_row_index,
  input  logic [dmm_pkg::POS_W-1:0]            in_col_index,
  input  logic signed [dmm_pkg::ELEM_W-1:0]    in_elem_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dmm_pkg::POS_W-1:0]            out_row,
  output logic [dmm_pkg::POS_W-1:0]            out_col,
  output logic signed [dmm_pkg::SUM_W-1:0]     out_product_value,
  output logic                                 out_last
);
  import dmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];

  logic [DIM_REG_W-1:0] a_rows_r;
  logic [DIM_REG_W-1:0] inner_size_r;
  logic [DIM_REG_W-1:0] b_cols_r;

  logic [DIM_W-1:0] dim_m;
  logic [DIM_W-1:0] dim_k;
  logic [DIM_W-1:0] dim_n;

  state_t state_r;
  state_t state_nxt;

  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;

  logic in_accept;
  logic wr_ok;
  logic wr_a;
  logic wr_b;
  logic [ADDR_W-1:0] wr_addr;
  logic rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic signed [ELEM_W-1:0] a_q_r;
  logic signed [ELEM_W-1:0] b_q_r;
  mac_ctrl_t s1_ctrl_r;
  mac_ctrl_t s1_ctrl_nxt;

  logic p_last;
  logic i_last;
  logic j_last;
  logic elem_last;
  logic out_free;
  logic out_load;

  logic signed [SUM_W-1:0] mac_acc;
  logic                    mac_done;

  logic                    out_valid_r;
  logic [POS_W-1:0]        out_row_r;
  logic [POS_W-1:0]        out_col_r;
  logic signed [SUM_W-1:0] out_value_r;
  logic                    out_last_r;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] reg_val);
    logic [DIM_W-1:0] d;
    if (reg_val == '0) begin
      d = DIM_W'(1);
    end else if (32'(reg_val) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(reg_val);
    end
    return d;
  endfunction

  assign dim_m = eff_dim(a_rows_r);
  assign dim_k = eff_dim(inner_size_r);
  assign dim_n = eff_dim(b_cols_r);

  assign p_last    = (DIM_W'(p_r) + DIM_W'(1)) == dim_k;
  assign i_last    = (DIM_W'(i_r) + DIM_W'(1)) == dim_m;
  assign j_last    = (DIM_W'(j_r) + DIM_W'(1)) == dim_n;
  assign elem_last = i_last && j_last;

  assign in_accept = in_valid && !in_stall;
  assign wr_ok     = (32'(in_row_index) < MAX_DIM) && (32'(in_col_index) < MAX_DIM);
  assign wr_a      = in_accept && wr_ok && (in_command == CMD_WRITE_A);
  assign wr_b      = in_accept && wr_ok && (in_command == CMD_WRITE_B);
  assign wr_addr   = ADDR_W'(in_row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col_index);
  assign rd_addr_a = ADDR_W'(i_r) * ADDR_W'(MAX_DIM) + ADDR_W'(p_r);
  assign rd_addr_b = ADDR_W'(p_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r);

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r     <= DIM_REG_W'(8);
      inner_size_r <= DIM_REG_W'(8);
      b_cols_r     <= DIM_REG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_ROWS:     a_rows_r     <= cfg_data;
        CFG_INNER_SIZE: inner_size_r <= cfg_data;
        CFG_B_COLS:     b_cols_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_command == CMD_COMPUTE)) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (p_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_nxt = elem_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    s1_ctrl_nxt = '0;
    i_nxt       = i_r;
    j_nxt       = j_r;
    p_nxt       = p_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        i_nxt    = '0;
        j_nxt    = '0;
        p_nxt    = '0;
      end
      ST_ISSUE: begin
        rd_en             = 1'b1;
        s1_ctrl_nxt.valid = 1'b1;
        s1_ctrl_nxt.first = (p_r == '0);
        s1_ctrl_nxt.last  = p_last;
        p_nxt             = p_last ? '0 : p_r + IDX_W'(1);
      end
      ST_WAIT: begin
        out_load = mac_done && out_free;
        if (out_load) begin
          if (j_last) begin
            j_nxt = '0;
            i_nxt = i_last ? '0 : i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      p_r       <= '0;
      s1_ctrl_r <= '0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      p_r       <= p_nxt;
      s1_ctrl_r <= s1_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= in_elem_value;
    end
    if (wr_b) begin
      b_mem[wr_addr] <= in_elem_value;
    end
    if (rd_en) begin
      a_q_r <= a_mem[rd_addr_a];
      b_q_r <= b_mem[rd_addr_b];
    end
  end

  dmm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .a_data (a_q_r),
    .b_data (b_q_r),
    .ctrl   (s1_ctrl_r),
    .take   (out_load),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r   <= POS_W'(i_r);
      out_col_r   <= POS_W'(j_r);
      out_value_r <= mac_acc;
      out_last_r  <= elem_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_value_r;
  assign out_last          = out_last_r;

  ap_read_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctrl_r.valid |-> $past(state_r == ST_ISSUE))
    else $error("read data valid without an issue cycle");

  ap_no_done_in_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> !mac_done)
    else $error("sum pending while next element is issued");

  ap_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctrl_r.valid && s1_ctrl_r.last) |-> ##2 mac_done)
    else $error("sum not ready two cycles after last term");

  ap_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && elem_last) |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after final element");

endmodule
